/* hw/rtl/update_log_newest_record_scan_core_assert.svh */
// ----------------------------------------------------------------------------
// Update log scan assertion macros
// Short forms for same-cycle and next-cycle implications under reset.
// ----------------------------------------------------------------------------
`ifndef UPDATE_LOG_NEWEST_RECORD_SCAN_CORE_ASSERT_SVH
`define UPDATE_LOG_NEWEST_RECORD_SCAN_CORE_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define ULNRS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ulnrs assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define ULNRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ulnrs assertion failed");

`endif

/* hw/rtl/ulnrs_pkg.sv */
// ----------------------------------------------------------------------------
// Update log scan package
// Word types, record layout constants and the parallel CRC-32 matrix.
// ----------------------------------------------------------------------------
package ulnrs_pkg;

   typedef struct packed {
      logic [31:0] log_word;
      logic        log_end;
   } req_word_type;

   typedef struct packed {
      logic        found;
      logic [31:0] newest_seq;
      logic [7:0]  newest_index;
      logic [7:0]  run_slot;
      logic [7:0]  last_slot;
      logic        boot_trial;
      logic [7:0]  attempts;
      logic        swap_pending;
      logic [7:0]  swap_slot;
      logic [7:0]  path_length;
      logic [7:0]  append_index;
      logic        erase_needed;
   } rsp_word_type;

   // end-of-record summary from the record checker
   typedef struct packed {
      logic        done;
      logic        ok;
      logic        blank;
      logic [31:0] seq;
      logic [31:0] slots_word;
      logic [31:0] request_word;
   } rec_done_type;

   typedef logic [31:0][31:0] crc_mat_type;

   localparam logic [31:0] LOG_MAGIC        = 32'h4947_5553;
   localparam logic [31:0] LOG_VERSION      = 32'h0000_0001;
   localparam logic [31:0] ERASED_WORD      = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY         = 32'h04C1_1DB7;
   localparam logic [15:0] PATH_LIMIT       = 16'd223;
   localparam logic [31:0] DEFAULT_REQ_WORD = 32'h0000_0100;

   localparam logic [5:0] WORD_MAGIC   = 6'd0;
   localparam logic [5:0] WORD_VERSION = 6'd1;
   localparam logic [5:0] WORD_SEQ     = 6'd2;
   localparam logic [5:0] WORD_SLOTS   = 6'd3;
   localparam logic [5:0] WORD_REQUEST = 6'd4;
   localparam logic [5:0] WORD_CRC     = 6'd63;

   localparam logic REG_SLOT_COUNT = 1'b0;
   localparam logic REG_TRIAL_CODE = 1'b1;

   localparam logic [7:0] SLOT_COUNT_RESET = 8'd2;
   localparam logic [7:0] TRIAL_CODE_RESET = 8'd1;

   // column i: CRC of a word with only bit i set, zero start value
   function automatic crc_mat_type crc_columns();
      crc_mat_type m;
      logic [31:0] c;
      for (int i = 0; i < 32; i++) begin
         c = 32'(1) << i;
         for (int b = 0; b < 32; b++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
         end
         m[i] = c;
      end
      return m;
   endfunction

   localparam crc_mat_type CRC_COLUMNS = crc_columns();

endpackage

/* hw/rtl/ulnrs_rec_check.sv */
// ----------------------------------------------------------------------------
// Update log record checker
// Tracks the word position, running CRC and header checks of one record.
// ----------------------------------------------------------------------------
module ulnrs_rec_check (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [31:0]             word,
   input  logic                    log_end,
   input  logic [7:0]              slot_count,
   output ulnrs_pkg::rec_done_type rec
);

   logic [5:0]  wp_ff, wp_in;
   logic [31:0] crc_ff, crc_in;
   logic        ok_ff, ok_in;
   logic        blank_ff, blank_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] slots_ff, slots_in;
   logic [31:0] req_ff, req_in;

   logic [31:0] crc_x;
   logic [31:0] crc_step;
   logic        ok_now;
   logic        blank_now;
   logic [31:0] seq_now;
   logic [31:0] slots_now;
   logic [31:0] req_now;
   logic        last;

   always_comb begin
      crc_x    = crc_ff ^ word;
      crc_step = '0;
      for (int i = 0; i < 32; i++) begin
         if (crc_x[i]) begin
            crc_step = crc_step ^ ulnrs_pkg::CRC_COLUMNS[i];
         end
      end

      blank_now = blank_ff && (word == ulnrs_pkg::ERASED_WORD);
      ok_now    = ok_ff;
      seq_now   = seq_ff;
      slots_now = slots_ff;
      req_now   = req_ff;
      case (wp_ff)
         ulnrs_pkg::WORD_MAGIC: begin
            if (word != ulnrs_pkg::LOG_MAGIC) ok_now = 1'b0;
         end
         ulnrs_pkg::WORD_VERSION: begin
            if (word != ulnrs_pkg::LOG_VERSION) ok_now = 1'b0;
         end
         ulnrs_pkg::WORD_SEQ: begin
            seq_now = word;
         end
         ulnrs_pkg::WORD_SLOTS: begin
            slots_now = word;
            if (word[7:0] >= slot_count || word[15:8] >= slot_count) ok_now = 1'b0;
         end
         ulnrs_pkg::WORD_REQUEST: begin
            req_now = word;
            if (word[15:8] >= slot_count || word[31:16] > ulnrs_pkg::PATH_LIMIT) begin
               ok_now = 1'b0;
            end
         end
         default: ;
      endcase
      last = (wp_ff == ulnrs_pkg::WORD_CRC);
      if (last && word != crc_ff) ok_now = 1'b0;

      rec.done         = step && last;
      rec.ok           = ok_now;
      rec.blank        = blank_now;
      rec.seq          = seq_now;
      rec.slots_word   = slots_now;
      rec.request_word = req_now;

      wp_in    = wp_ff;
      crc_in   = crc_ff;
      ok_in    = ok_ff;
      blank_in = blank_ff;
      seq_in   = seq_ff;
      slots_in = slots_ff;
      req_in   = req_ff;
      if (step) begin
         if (last || log_end) begin
            wp_in    = '0;
            crc_in   = ulnrs_pkg::CRC_INIT;
            ok_in    = 1'b1;
            blank_in = 1'b1;
            seq_in   = '0;
            slots_in = '0;
            req_in   = '0;
         end else begin
            wp_in    = wp_ff + 6'd1;
            crc_in   = crc_step;
            ok_in    = ok_now;
            blank_in = blank_now;
            seq_in   = seq_now;
            slots_in = slots_now;
            req_in   = req_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         crc_ff   <= ulnrs_pkg::CRC_INIT;
         ok_ff    <= 1'b1;
         blank_ff <= 1'b1;
         seq_ff   <= '0;
         slots_ff <= '0;
         req_ff   <= '0;
      end else begin
         wp_ff    <= wp_in;
         crc_ff   <= crc_in;
         ok_ff    <= ok_in;
         blank_ff <= blank_in;
         seq_ff   <= seq_in;
         slots_ff <= slots_in;
         req_ff   <= req_in;
      end
   end

endmodule

/* hw/rtl/update_log_newest_record_scan_core.sv */
// Scans an append log one 32-bit word per cycle and reports the newest valid
// record when the word marked log_end arrives. Each word is taken into an
// input register and processed from there by the record checker (a
// 32-bit parallel CRC-32/MPEG-2 XOR matrix plus header checks) and the
// newest-record compare; the result register captures the report when the
// end word leaves the input register. Words are accepted back to back every
// cycle; only an end word waits in the input register while an earlier
// report has not yet been taken. Configuration sits at csr address 0
// (slot_count) and 4 (trial_code).
// ----------------------------------------------------------------------------
// Update log newest record scan core
// Record validation, newest-record selection and append/erase decision.
// ----------------------------------------------------------------------------
module update_log_newest_record_scan_core #(
   parameter int RECORD_COUNT = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ulnrs_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ulnrs_pkg::rsp_word_type rsp_word,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam int POS_W = $clog2(RECORD_COUNT + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(RECORD_COUNT);
   localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);

   logic [7:0] slot_count_ff;
   logic [7:0] trial_code_ff;
   logic       csr_write;

   logic                    in_valid_ff, in_valid_in;
   ulnrs_pkg::req_word_type in_word_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   ulnrs_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic                    step;
   logic                    finish;

   logic [POS_W-1:0] rec_pos_ff, rec_pos_in;
   logic             best_found_ff, best_found_in;
   logic [31:0]      best_seq_ff, best_seq_in;
   logic [POS_W-1:0] best_pos_ff, best_pos_in;
   logic [31:0]      best_slots_ff, best_slots_in;
   logic [31:0]      best_req_ff, best_req_in;
   logic             first_blank_ff, first_blank_in;
   logic             after_blank_ff, after_blank_in;

   logic [31:0]      sw;
   logic [31:0]      rw;
   logic [POS_W-1:0] app_next;

   ulnrs_pkg::rec_done_type rec;

   ulnrs_rec_check u_rec_check (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .word       (in_word_ff.log_word),
      .log_end    (in_word_ff.log_end),
      .slot_count (slot_count_ff),
      .rec        (rec)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[2])
         ulnrs_pkg::REG_SLOT_COUNT: csr_prdata = {24'd0, slot_count_ff};
         ulnrs_pkg::REG_TRIAL_CODE: csr_prdata = {24'd0, trial_code_ff};
      endcase
   end

   assign step      = in_valid_ff && (!in_word_ff.log_end || !rsp_valid_ff || rsp_ready);
   assign finish    = step && in_word_ff.log_end;
   assign req_ready = !in_valid_ff || step;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      rec_pos_in     = rec_pos_ff;
      best_found_in  = best_found_ff;
      best_seq_in    = best_seq_ff;
      best_pos_in    = best_pos_ff;
      best_slots_in  = best_slots_ff;
      best_req_in    = best_req_ff;
      first_blank_in = first_blank_ff;
      after_blank_in = after_blank_ff;

      if (rec.done && rec_pos_ff < POS_LIMIT) begin
         if (rec.ok && (!best_found_ff || rec.seq > best_seq_ff)) begin
            best_found_in  = 1'b1;
            best_seq_in    = rec.seq;
            best_pos_in    = rec_pos_ff;
            best_slots_in  = rec.slots_word;
            best_req_in    = rec.request_word;
            after_blank_in = 1'b0;
         end else if (best_found_ff && rec_pos_ff == best_pos_ff + POS_ONE) begin
            after_blank_in = rec.blank;
         end
         if (rec_pos_ff == '0) first_blank_in = rec.blank;
         rec_pos_in = rec_pos_ff + POS_ONE;
      end

      // report from the state including the record just closed
      sw = best_found_in ? best_slots_in : '0;
      rw = best_found_in ? best_req_in : ulnrs_pkg::DEFAULT_REQ_WORD;
      app_next = best_pos_in + POS_ONE;
      rsp_word_in.found        = best_found_in;
      rsp_word_in.newest_seq   = best_found_in ? best_seq_in : '0;
      rsp_word_in.newest_index = best_found_in ? 8'(best_pos_in) : 8'd0;
      rsp_word_in.run_slot     = sw[7:0];
      rsp_word_in.last_slot    = sw[15:8];
      rsp_word_in.boot_trial   = best_found_in && (sw[23:16] == trial_code_ff);
      rsp_word_in.attempts     = sw[31:24];
      rsp_word_in.swap_pending = (rw[7:0] != 8'd0);
      rsp_word_in.swap_slot    = rw[15:8];
      rsp_word_in.path_length  = rw[23:16];
      if (best_seq_in == '0) begin
         rsp_word_in.append_index = 8'd0;
         rsp_word_in.erase_needed = !first_blank_in;
      end else if (app_next >= POS_LIMIT || !after_blank_in) begin
         rsp_word_in.append_index = 8'd0;
         rsp_word_in.erase_needed = 1'b1;
      end else begin
         rsp_word_in.append_index = 8'(app_next);
         rsp_word_in.erase_needed = 1'b0;
      end

      if (finish) begin
         rec_pos_in     = '0;
         best_found_in  = 1'b0;
         best_seq_in    = '0;
         best_pos_in    = '0;
         best_slots_in  = '0;
         best_req_in    = '0;
         first_blank_in = 1'b0;
         after_blank_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff  <= ulnrs_pkg::SLOT_COUNT_RESET;
         trial_code_ff  <= ulnrs_pkg::TRIAL_CODE_RESET;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rec_pos_ff     <= '0;
         best_found_ff  <= 1'b0;
         best_seq_ff    <= '0;
         best_pos_ff    <= '0;
         best_slots_ff  <= '0;
         best_req_ff    <= '0;
         first_blank_ff <= 1'b0;
         after_blank_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_paddr[2])
               ulnrs_pkg::REG_SLOT_COUNT: slot_count_ff <= csr_pwdata[7:0];
               ulnrs_pkg::REG_TRIAL_CODE: trial_code_ff <= csr_pwdata[7:0];
            endcase
         end
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         rec_pos_ff     <= rec_pos_in;
         best_found_ff  <= best_found_in;
         best_seq_ff    <= best_seq_in;
         best_pos_ff    <= best_pos_in;
         best_slots_ff  <= best_slots_in;
         best_req_ff    <= best_req_in;
         first_blank_ff <= first_blank_in;
         after_blank_ff <= after_blank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_word_ff <= req_word;
      if (finish) rsp_word_ff <= rsp_word_in;
   end

endmodule

/* hw/rtl/ulnrs_checker.sv */
// ----------------------------------------------------------------------------
// Update log scan port checker
// Watches the result channel and report consistency at the top level ports.
// ----------------------------------------------------------------------------
`include "update_log_newest_record_scan_core_assert.svh"

module ulnrs_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input ulnrs_pkg::rsp_word_type rsp_word
);

   logic       none_ok;
   logic       follow_ante;
   logic [7:0] next_index;
   logic       append_ok;

   assign none_ok     = rsp_word.newest_seq == 32'd0 && rsp_word.newest_index == 8'd0
                        && rsp_word.swap_slot == 8'd1 && !rsp_word.boot_trial;
   assign follow_ante = rsp_valid && rsp_word.found && !rsp_word.erase_needed
                        && rsp_word.newest_seq != 32'd0;
   assign next_index  = rsp_word.newest_index + 8'd1;
   assign append_ok   = (rsp_word.append_index == next_index);

   `ULNRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ULNRS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_word))
   `ULNRS_ASSERT_NOW(a_none_defaults, clock, reset, rsp_valid && !rsp_word.found, none_ok)
   `ULNRS_ASSERT_NOW(a_append_follows, clock, reset, follow_ante, append_ok)

endmodule

bind update_log_newest_record_scan_core ulnrs_checker u_ulnrs_checker (.*);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Update log newest record scan testbench
// Streams generated logs of 64-word records into the scan core: good records,
// erased records, noise and every header, slot, path and CRC flaw, with
// partial tails and a log longer than the record limit. A predictor tracks
// the newest valid record and checks every report in order. Both handshake
// sides idle in random bursts, and the configuration is rewritten between
// logs.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RECORDS         = 256;
   localparam int RANDOM_WORDS    = 1950;
   localparam int MIN_RANDOM_LOGS = 40;
   localparam int LONG_HOLD       = 150;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [2:0] ADDR_SLOT_COUNT = {ulnrs_pkg::REG_SLOT_COUNT, 2'b00};
   localparam logic [2:0] ADDR_TRIAL_CODE = {ulnrs_pkg::REG_TRIAL_CODE, 2'b00};

   typedef enum int {
      REC_GOOD,
      REC_ERASED,
      REC_NOISE,
      REC_BAD_MAGIC,
      REC_BAD_VERSION,
      REC_BAD_BOOT,
      REC_BAD_PREV,
      REC_BAD_REQ_SLOT,
      REC_BAD_PATH,
      REC_BAD_CRC
   } rec_kind_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   ulnrs_pkg::req_word_type req_word    = '0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   ulnrs_pkg::rsp_word_type rsp_word;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [2:0]              csr_paddr   = '0;
   logic [31:0]             csr_pwdata  = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   update_log_newest_record_scan_core #(
      .RECORD_COUNT(RECORDS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   ulnrs_pkg::req_word_type log_feed[$];
   ulnrs_pkg::rsp_word_type due_reports[$];
   logic [31:0]             log_words[$];

   int error_count  = 0;
   int words_queued = 0;
   int send_gap     = 0;
   int stall_left   = 0;
   int hold_left    = 0;
   int holds_asked  = 0;
   int holds_served = 0;
   bit send_idle    = 1'b0;
   bit recv_idle    = 1'b0;
   bit calm         = 1'b0;

   logic [7:0] slot_cnt = ulnrs_pkg::SLOT_COUNT_RESET;
   logic [7:0] trial_cd = ulnrs_pkg::TRIAL_CODE_RESET;

   // scan predictor state
   logic [5:0]  wpos;
   logic [8:0]  rpos;
   logic [31:0] crc;
   logic        rec_good;
   logic        rec_erased;
   logic [31:0] cur_seq;
   logic [31:0] cur_slots;
   logic [31:0] cur_req;
   logic        have_best;
   logic [31:0] top_seq;
   logic [8:0]  top_pos;
   logic [31:0] top_slots;
   logic [31:0] top_req;
   logic        zero_erased;
   logic        next_erased;

   function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [31:0] w);
      logic [31:0] c;
      c = acc ^ w;
      for (int b = 0; b < 32; b++) begin
         c = c[31] ? ((c << 1) ^ ulnrs_pkg::CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   task automatic open_record();
      wpos       = '0;
      crc        = ulnrs_pkg::CRC_INIT;
      rec_good   = 1'b1;
      rec_erased = 1'b1;
      cur_seq    = '0;
      cur_slots  = '0;
      cur_req    = '0;
   endtask

   task automatic clear_scan();
      open_record();
      rpos        = '0;
      have_best   = 1'b0;
      top_seq     = '0;
      top_pos     = '0;
      top_slots   = '0;
      top_req     = '0;
      zero_erased = 1'b0;
      next_erased = 1'b0;
   endtask

   task automatic scan_word(input ulnrs_pkg::req_word_type item);
      ulnrs_pkg::rsp_word_type rep;
      logic [31:0]             w;
      logic [31:0]             sw;
      logic [31:0]             rw;
      logic [8:0]              nxt;
      w = item.log_word;
      if (w != ulnrs_pkg::ERASED_WORD) rec_erased = 1'b0;
      case (wpos)
         ulnrs_pkg::WORD_MAGIC: if (w != ulnrs_pkg::LOG_MAGIC) rec_good = 1'b0;
         ulnrs_pkg::WORD_VERSION: if (w != ulnrs_pkg::LOG_VERSION) rec_good = 1'b0;
         ulnrs_pkg::WORD_SEQ: cur_seq = w;
         ulnrs_pkg::WORD_SLOTS: begin
            cur_slots = w;
            if (w[7:0] >= slot_cnt || w[15:8] >= slot_cnt) rec_good = 1'b0;
         end
         ulnrs_pkg::WORD_REQUEST: begin
            cur_req = w;
            if (w[15:8] >= slot_cnt || w[31:16] > ulnrs_pkg::PATH_LIMIT) rec_good = 1'b0;
         end
         default: ;
      endcase
      if (wpos != ulnrs_pkg::WORD_CRC) begin
         crc  = crc_step(crc, w);
         wpos = wpos + 6'd1;
      end else begin
         if (w != crc) rec_good = 1'b0;
         if (rpos < RECORDS) begin
            if (rec_good && (!have_best || cur_seq > top_seq)) begin
               have_best   = 1'b1;
               top_seq     = cur_seq;
               top_pos     = rpos;
               top_slots   = cur_slots;
               top_req     = cur_req;
               next_erased = 1'b0;
            end else if (have_best && rpos == top_pos + 9'd1) begin
               next_erased = rec_erased;
            end
            if (rpos == 0) zero_erased = rec_erased;
            rpos = rpos + 9'd1;
         end
         open_record();
      end
      if (item.log_end) begin
         sw = have_best ? top_slots : '0;
         rw = have_best ? top_req : ulnrs_pkg::DEFAULT_REQ_WORD;
         rep.found        = have_best;
         rep.newest_seq   = have_best ? top_seq : '0;
         rep.newest_index = have_best ? top_pos[7:0] : '0;
         rep.run_slot     = sw[7:0];
         rep.last_slot    = sw[15:8];
         rep.boot_trial   = have_best && (sw[23:16] == trial_cd);
         rep.attempts     = sw[31:24];
         rep.swap_pending = (rw[7:0] != 8'd0);
         rep.swap_slot    = rw[15:8];
         rep.path_length  = rw[23:16];
         if (top_seq == 0) begin
            rep.append_index = '0;
            rep.erase_needed = !zero_erased;
         end else begin
            nxt = top_pos + 9'd1;
            if (nxt >= RECORDS || !next_erased) begin
               rep.append_index = '0;
               rep.erase_needed = 1'b1;
            end else begin
               rep.append_index = nxt[7:0];
               rep.erase_needed = 1'b0;
            end
         end
         due_reports.push_back(rep);
         clear_scan();
      end
   endtask

   function automatic string show_report(input ulnrs_pkg::rsp_word_type r);
      return $sformatf({"found=%0d seq=%h index=%0d boot=%0d prev=%0d trial=%0d ",
                        "attempts=%0d pend=%0d rslot=%0d path=%0d append=%0d erase=%0d"},
                       r.found, r.newest_seq, r.newest_index, r.run_slot, r.last_slot,
                       r.boot_trial, r.attempts, r.swap_pending, r.swap_slot,
                       r.path_length, r.append_index, r.erase_needed);
   endfunction

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("mismatch at %0t: %s", $time, what);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         clear_scan();
      end else begin
         if (req_valid && req_ready) scan_word(req_word);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (send_idle && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 6) - 1;
               req_valid <= 1'b0;
            end else if (log_feed.size() > 0) begin
               req_word  <= log_feed.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and report check
   always @(posedge clock) begin
      ulnrs_pkg::rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_reports.size() == 0) begin
               flag_error($sformatf("unexpected report %s", show_report(rsp_word)));
            end else begin
               want = due_reports.pop_front();
               if (rsp_word !== want) begin
                  flag_error($sformatf("\n  exp %s\n  got %s", show_report(want),
                                       show_report(rsp_word)));
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (recv_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic csr_write(input logic [2:0] addr, input logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input logic [2:0] addr, input logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== value) begin
         flag_error($sformatf("csr %0d read exp %h got %h", addr, value, csr_prdata));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (log_feed.size() != 0 || req_valid || due_reports.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_setting(input logic [7:0] sc, input logic [7:0] tc);
      wait_drained();
      csr_write(ADDR_SLOT_COUNT, sc);
      csr_write(ADDR_TRIAL_CODE, tc);
      slot_cnt = sc;
      trial_cd = tc;
      csr_check(ADDR_SLOT_COUNT, sc);
      csr_check(ADDR_TRIAL_CODE, tc);
   endtask

   function automatic logic [31:0] pick_seq();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3);
         1: return $urandom_range(0, 40);
         2: return $urandom;
         default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      endcase
   endfunction

   function automatic logic [31:0] make_slots();
      logic [7:0]  top;
      logic [31:0] s;
      top      = (slot_cnt == 0) ? 8'hFF : slot_cnt - 8'd1;
      s[7:0]   = ($urandom_range(0, 3) == 0) ? top : 8'($urandom_range(0, top));
      s[15:8]  = 8'($urandom_range(0, top));
      s[23:16] = $urandom_range(0, 1) ? trial_cd : 8'($urandom);
      s[31:24] = 8'($urandom);
      return s;
   endfunction

   function automatic logic [31:0] make_request();
      logic [7:0]  top;
      logic [31:0] r;
      top      = (slot_cnt == 0) ? 8'hFF : slot_cnt - 8'd1;
      r[7:0]   = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
      r[15:8]  = 8'($urandom_range(0, top));
      r[31:16] = ($urandom_range(0, 3) == 0) ? 16'd223 : 16'($urandom_range(0, 223));
      return r;
   endfunction

   task automatic add_record(input rec_kind_type kind, input logic [31:0] seq,
                             input logic [31:0] slots, input logic [31:0] request);
      logic [31:0] w[64];
      logic [31:0] c;
      for (int i = 0; i < 64; i++) begin
         w[i] = ($urandom_range(0, 15) == 0) ? ulnrs_pkg::ERASED_WORD : $urandom;
      end
      if (kind == REC_ERASED) begin
         for (int i = 0; i < 64; i++) w[i] = ulnrs_pkg::ERASED_WORD;
      end else if (kind != REC_NOISE) begin
         w[ulnrs_pkg::WORD_MAGIC]   = ulnrs_pkg::LOG_MAGIC;
         w[ulnrs_pkg::WORD_VERSION] = ulnrs_pkg::LOG_VERSION;
         w[ulnrs_pkg::WORD_SEQ]     = seq;
         w[ulnrs_pkg::WORD_SLOTS]   = slots;
         w[ulnrs_pkg::WORD_REQUEST] = request;
         case (kind)
            REC_BAD_MAGIC: w[ulnrs_pkg::WORD_MAGIC] ^= 32'd1 << $urandom_range(0, 31);
            REC_BAD_VERSION: w[ulnrs_pkg::WORD_VERSION] ^= 32'd1 << $urandom_range(0, 31);
            REC_BAD_BOOT:
               w[ulnrs_pkg::WORD_SLOTS][7:0] = 8'($urandom_range(slot_cnt, 255));
            REC_BAD_PREV:
               w[ulnrs_pkg::WORD_SLOTS][15:8] = 8'($urandom_range(slot_cnt, 255));
            REC_BAD_REQ_SLOT:
               w[ulnrs_pkg::WORD_REQUEST][15:8] = 8'($urandom_range(slot_cnt, 255));
            REC_BAD_PATH:
               w[ulnrs_pkg::WORD_REQUEST][31:16] = 16'($urandom_range(224, 65535));
            default: ;
         endcase
         c = ulnrs_pkg::CRC_INIT;
         for (int i = 0; i < 63; i++) c = crc_step(c, w[i]);
         w[ulnrs_pkg::WORD_CRC] = (kind == REC_BAD_CRC)
                                  ? c ^ (32'd1 << $urandom_range(0, 31)) : c;
      end
      for (int i = 0; i < 64; i++) log_words.push_back(w[i]);
   endtask

   task automatic send_log(input int tail);
      ulnrs_pkg::req_word_type item;
      for (int i = 0; i < tail; i++) log_words.push_back($urandom);
      if (log_words.size() == 0) log_words.push_back($urandom);
      do @(negedge clock); while (log_feed.size() != 0);
      send_idle = !calm && ($urandom_range(0, 4) != 0);
      recv_idle = !calm && ($urandom_range(0, 4) != 0);
      while (log_words.size() > 0) begin
         item.log_word = log_words.pop_front();
         item.log_end  = (log_words.size() == 0);
         log_feed.push_back(item);
         words_queued++;
      end
   endtask

   task automatic send_random_log();
      int           n;
      int           r;
      rec_kind_type kind;
      r = $urandom_range(0, 19);
      n = (r < 5) ? 0 : (r < 12) ? 1 : (r < 17) ? 2 : $urandom_range(3, 4);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 19);
         if (r < 11) kind = REC_GOOD;
         else if (r < 14) kind = REC_ERASED;
         else if (r == 14) kind = REC_NOISE;
         else kind = rec_kind_type'($urandom_range(REC_BAD_MAGIC, REC_BAD_CRC));
         add_record(kind, pick_seq(), make_slots(), make_request());
      end
      r = $urandom_range(0, 3);
      send_log((r < 2) ? 0 : (r == 2) ? $urandom_range(1, 8) : $urandom_range(9, 63));
   endtask

   initial begin
      int rand_start;
      int rand_logs;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      csr_check(ADDR_SLOT_COUNT, ulnrs_pkg::SLOT_COUNT_RESET);
      csr_check(ADDR_TRIAL_CODE, ulnrs_pkg::TRIAL_CODE_RESET);

      // no full record
      send_log(1);
      // newest record, then an erased record that closes on the end word
      add_record(REC_GOOD, 32'd5, {8'd3, trial_cd, 8'd1, 8'd0}, {16'd17, 8'd1, 8'd0});
      add_record(REC_ERASED, '0, '0, '0);
      send_log(0);
      // every flaw outranks nothing; tie keeps the earliest
      add_record(REC_GOOD, 32'd3, make_slots(), make_request());
      for (int k = REC_NOISE; k <= REC_BAD_CRC; k++) begin
         add_record(rec_kind_type'(k), 32'd100, make_slots(), make_request());
      end
      add_record(REC_GOOD, 32'd3, make_slots(), make_request());
      send_log(10);
      // top sequence, longest path, record after it not erased
      add_record(REC_GOOD, 32'hFFFF_FFFF, {8'hFF, trial_cd, 8'd1, 8'd1},
                 {16'd223, 8'd1, 8'hFF});
      add_record(REC_NOISE, '0, '0, '0);
      send_log(0);
      // erased first record only
      add_record(REC_ERASED, '0, '0, '0);
      send_log(0);
      // newest record has sequence zero
      add_record(REC_GOOD, 32'd0, make_slots(), make_request());
      add_record(REC_ERASED, '0, '0, '0);
      send_log(5);
      // partial record only
      send_log(63);
      // past the record limit: last counted record wins, the one beyond is dropped
      for (int i = 0; i < RECORDS - 1; i++) add_record(REC_ERASED, '0, '0, '0);
      add_record(REC_GOOD, 32'd7, make_slots(), make_request());
      add_record(REC_GOOD, 32'd9, make_slots(), make_request());
      send_log(5);

      // receiver holds off while short logs pile up
      wait_drained();
      holds_asked++;
      for (int i = 0; i < 6; i++) send_log($urandom_range(1, 3));
      add_record(REC_GOOD, pick_seq(), make_slots(), make_request());
      send_log(0);

      apply_setting(8'd0, 8'd0);
      add_record(REC_GOOD, 32'd4, make_slots(), make_request());
      add_record(REC_ERASED, '0, '0, '0);
      send_log(0);
      apply_setting(8'd255, 8'd255);
      add_record(REC_GOOD, 32'd8, {8'($urandom), 8'hFF, 8'd254, 8'd254},
                 {16'd0, 8'd254, 8'd1});
      add_record(REC_ERASED, '0, '0, '0);
      send_log(0);
      apply_setting(8'd1, 8'd0);
      send_random_log();

      rand_start = words_queued;
      rand_logs  = 0;
      while (words_queued - rand_start < RANDOM_WORDS || rand_logs < MIN_RANDOM_LOGS) begin
         if (rand_logs % 6 == 5) begin
            apply_setting(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                      : 8'($urandom_range(1, 4)),
                          ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                      : 8'($urandom));
         end
         send_random_log();
         rand_logs++;
      end

      calm = 1'b1;
      for (int i = 0; i < 4; i++) send_random_log();

      wait_drained();
      repeat (20) @(negedge clock);
      if (error_count == 0 && due_reports.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ulnrs_pkg.sv
hw/rtl/ulnrs_rec_check.sv
hw/rtl/update_log_newest_record_scan_core.sv
hw/rtl/ulnrs_checker.sv
tb/tb_top.sv
